@@ sv/pidsd_pkg.sv @@
package pidsd_pkg;

  // Field and state widths.
  localparam int GainW  = 16;
  localparam int LimW   = 15;
  localparam int CountW = 10;
  localparam int DataW  = 16;
  localparam int ErrW   = 17;
  // The integral is held within +/- (2^15 - 1) * 256, so 25 signed bits suffice.
  localparam int IntW   = 25;
  localparam int IdxW   = 3;

  typedef enum logic [IdxW-1:0] {
    RegGainP      = 3'd0,
    RegGainI      = 3'd1,
    RegGainD      = 3'd2,
    RegMaxDrive   = 3'd3,
    RegIntBound   = 3'd4,
    RegDeadband   = 3'd5,
    RegStallLimit = 3'd6
  } reg_idx_e;

  localparam logic [LimW-1:0]   MaxDriveRst   = 15'd16384;
  localparam logic [LimW-1:0]   IntBoundRst   = 15'd5000;
  localparam logic [LimW-1:0]   DeadbandRst   = 15'd5;
  localparam logic [CountW-1:0] StallLimitRst = 10'd1000;
  localparam logic [CountW-1:0] CountMax      = '1;

  typedef struct packed {
    logic [GainW-1:0]  gain_p;
    logic [GainW-1:0]  gain_i;
    logic [GainW-1:0]  gain_d;
    logic [LimW-1:0]   max_drive;
    logic [LimW-1:0]   integral_bound;
    logic [LimW-1:0]   deadband;
    logic [CountW-1:0] stall_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [IntW-1:0] integral;
    logic signed [ErrW-1:0] prev_err;
    logic [CountW-1:0]      count;
    logic                   flag;
  } loop_state_t;

endpackage

@@ sv/pidsd_step.sv @@
module pidsd_step (
  input  pidsd_pkg::cfg_t        cfg_i,
  input  pidsd_pkg::loop_state_t state_i,
  input  logic                   action_i,
  input  logic signed [15:0]     measured_i,
  input  logic signed [15:0]     target_i,
  output pidsd_pkg::loop_state_t state_o,
  output logic signed [15:0]     drive_o,
  output logic                   stalled_o
);
  import pidsd_pkg::*;

  localparam int ProdW = 34;
  localparam int DProdW = 35;
  localparam int RawW = 35;
  localparam int SumW = 38;
  localparam int ScaledW = 46;

  logic signed [ErrW-1:0]    err;
  logic signed [ErrW:0]      err_diff;
  logic signed [ErrW-1:0]    gp, gi, gd;
  logic signed [ProdW-1:0]   p_prod, i_prod;
  logic signed [DProdW-1:0]  d_prod;
  logic signed [RawW-1:0]    int_raw;
  logic signed [SumW-1:0]    sum;
  logic signed [ScaledW-1:0] sum_w, sum_x100;
  logic signed [IntW-1:0]    int_lim, drv_lim, int_clamped, clamped;
  logic                      active, counts, tgt_zero, tgt_pos, dead;
  logic [ErrW-1:0]           abs_e;
  logic [20:0]               e_x10, t_x9;
  logic [CountW-1:0]         count_next;
  logic [IntW-2:0]           mag;
  logic [15:0]               mag_int;

  assign err = ErrW'(target_i) - ErrW'(measured_i);
  assign err_diff = (ErrW+1)'(err) - (ErrW+1)'(state_i.prev_err);

  assign gp = $signed({1'b0, cfg_i.gain_p});
  assign gi = $signed({1'b0, cfg_i.gain_i});
  assign gd = $signed({1'b0, cfg_i.gain_d});

  assign p_prod = gp * err;
  assign i_prod = gi * err;
  assign d_prod = gd * err_diff;

  // The raw sum takes the integral before it is clamped.
  assign int_raw = RawW'(state_i.integral) + RawW'(i_prod);
  assign sum = SumW'(p_prod) + SumW'(int_raw) + SumW'(d_prod);

  assign int_lim = $signed({2'b00, cfg_i.integral_bound, 8'h00});
  assign drv_lim = $signed({2'b00, cfg_i.max_drive, 8'h00});

  always_comb begin
    if (int_raw > RawW'(int_lim)) begin
      int_clamped = int_lim;
    end else if (int_raw < -RawW'(int_lim)) begin
      int_clamped = -int_lim;
    end else begin
      int_clamped = int_raw[IntW-1:0];
    end
  end

  // One percent test: sum * 100 >= max_drive * 256, with 100 = 64 + 32 + 4.
  assign sum_w = ScaledW'(sum);
  assign sum_x100 = (sum_w <<< 6) + (sum_w <<< 5) + (sum_w <<< 2);
  assign active = sum_x100 >= ScaledW'(drv_lim);

  // Ninety percent test without a divider: 10 * |e| > 9 * target.
  assign abs_e = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
  assign e_x10 = 21'({abs_e, 3'b000}) + 21'({abs_e, 1'b0});
  assign t_x9 = 21'({target_i[14:0], 3'b000}) + 21'(target_i[14:0]);
  assign tgt_zero = target_i == 16'sd0;
  assign tgt_pos = !target_i[15] && !tgt_zero;

  always_comb begin
    counts = 1'b0;
    if (tgt_pos) begin
      counts = e_x10 > t_x9;
    end else if (tgt_zero) begin
      counts = err != '0;
    end
  end

  always_comb begin
    count_next = state_i.count;
    if (active) begin
      if (!counts) begin
        count_next = '0;
      end else if (state_i.count != CountMax) begin
        count_next = state_i.count + 1'b1;
      end
    end
  end

  always_comb begin
    if (sum > SumW'(drv_lim)) begin
      clamped = drv_lim;
    end else if (sum < -SumW'(drv_lim)) begin
      clamped = -drv_lim;
    end else begin
      clamped = sum[IntW-1:0];
    end
  end

  assign mag = clamped[IntW-1] ? (IntW-1)'(-clamped) : (IntW-1)'(clamped);
  assign mag_int = mag[IntW-2:8];
  assign dead = (cfg_i.deadband != '0) && (mag < (IntW-1)'({cfg_i.deadband, 8'h00}));

  always_comb begin
    if (action_i) begin
      state_o   = '0;
      drive_o   = '0;
      stalled_o = 1'b0;
    end else begin
      state_o.integral = int_clamped;
      state_o.prev_err = err;
      state_o.count    = count_next;
      state_o.flag     = state_i.flag | (active && (count_next > cfg_i.stall_limit));
      if (dead) begin
        drive_o = '0;
      end else if (clamped[IntW-1]) begin
        drive_o = -$signed(mag_int);
      end else begin
        drive_o = $signed(mag_int);
      end
      stalled_o = state_o.flag;
    end
  end

endmodule

@@ sv/pid_with_stall_detect.sv @@
// Position-form PID controller with integral anti-windup, output clamp,
// deadband and blocked-motor detection. Each word on the input channel either
// runs one control step on a signed target and measurement or, with action
// set, clears the integral, the last error, the stall count and the sticky
// stall flag. Gains are unsigned Q8.8; the loop math keeps 8 fraction bits and
// drive is the clamped sum truncated toward zero. A word is taken into an
// input register, the whole control step is computed from it and lands in
// an output register, so one word per cycle is sustained while the output
// is not stalled, and the result is valid once the word has moved from the
// input register into the output register. The rate is set by the loop
// through the integral and the last-error registers, which are updated as
// each word moves into the output register. While a result is
// stalled, one more word is still taken into the input register. Registers
// are written through the configuration channel, which is always ready, and
// should only be written while no word is in flight.
module pid_with_stall_detect (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pidsd_pkg::IdxW-1:0]           cfg_index_i,
  input  logic [pidsd_pkg::DataW-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 action_i,
  input  logic signed [15:0]                   measured_i,
  input  logic signed [15:0]                   target_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [15:0]                   drive_o,
  output logic                                 stalled_o
);
  import pidsd_pkg::*;

  cfg_t               cfg_q;
  loop_state_t        state_q, state_d;
  logic               in_valid_q, in_valid_d;
  logic               action_q;
  logic signed [15:0] measured_q, target_q;
  logic               out_valid_q, out_valid_d;
  logic signed [15:0] drive_q, drive_d;
  logic               stalled_q, stalled_d;
  logic               accept, advance;

  // The input register moves on whenever the output register is empty or
  // being emptied in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  assign cfg_ready_o = 1'b1;

  pidsd_step u_step (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .action_i   (action_q),
    .measured_i (measured_q),
    .target_i   (target_q),
    .state_o    (state_d),
    .drive_o    (drive_d),
    .stalled_o  (stalled_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.gain_d         <= '0;
      cfg_q.max_drive      <= MaxDriveRst;
      cfg_q.integral_bound <= IntBoundRst;
      cfg_q.deadband       <= DeadbandRst;
      cfg_q.stall_limit    <= StallLimitRst;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        RegGainP:      cfg_q.gain_p         <= cfg_data_i;
        RegGainI:      cfg_q.gain_i         <= cfg_data_i;
        RegGainD:      cfg_q.gain_d         <= cfg_data_i;
        RegMaxDrive:   cfg_q.max_drive      <= cfg_data_i[LimW-1:0];
        RegIntBound:   cfg_q.integral_bound <= cfg_data_i[LimW-1:0];
        RegDeadband:   cfg_q.deadband       <= cfg_data_i[LimW-1:0];
        RegStallLimit: cfg_q.stall_limit    <= cfg_data_i[CountW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q   <= action_i;
      measured_q <= measured_i;
      target_q   <= target_i;
    end
    if (advance) begin
      drive_q   <= drive_d;
      stalled_q <= stalled_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign stalled_o   = stalled_q;

`ifndef SYNTHESIS
  // The stall flag only drops through a clear word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.flag && !(advance && action_q) |=> state_q.flag)
    else $error("stall flag dropped without a clear");

  // A clear word leaves the whole loop state at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && action_q |=> state_q == '0)
    else $error("loop state not zeroed by a clear");

  // The flag rises only with a count beyond the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q.flag) |-> state_q.count > cfg_q.stall_limit)
    else $error("stall flag set with count within limit");

  // The result register never loses a stalled word to a new one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |-> !advance)
    else $error("result overwritten while stalled");
`endif

endmodule

@@ test/tb_pid_with_stall_detect.sv @@
`timescale 1ns / 100ps

// Testbench for the PID controller with stall detection.
// Every word that the block accepts on its input channel goes through a local
// model of the control step. The model keeps its own copy of the loop state
// and of the registers. The predicted drive and stall flag are queued, and a
// monitor compares each accepted result word with the oldest entry. The run
// starts with short directed tests. A long run then drives the stall counter
// into saturation. Randomized segments follow, each with a fresh register set.
// Both the sender and the receiver idle at random, with rates that change from
// phase to phase.
module tb_pid_with_stall_detect;
  import pidsd_pkg::*;

  localparam int CycleLimit = 300000;
  // Extra cycles after the last result before a register write or the end.
  // This covers the pipeline of the block with some margin.
  localparam int SettleCycles = 4;
  localparam logic ActRun   = 1'b0;
  localparam logic ActClear = 1'b1;
  // Index past the register list. The block must ignore writes to it.
  localparam logic [IdxW-1:0] RegUnused = 3'd7;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    stalled;
  } ctl_word_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [IdxW-1:0]         cfg_index_i = '0;
  logic [DataW-1:0]        cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic                    action_i = 1'b0;
  logic signed [15:0]      measured_i = '0;
  logic signed [15:0]      target_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [15:0]      drive_o;
  logic                    stalled_o;

  pid_with_stall_detect DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .measured_i  (measured_i),
    .target_i    (target_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_o     (drive_o),
    .stalled_o   (stalled_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // These are the register values as the block should hold them, masked to
  // their widths. Next to them is the loop state of the local model.
  cfg_t               loop_cfg;
  longint             integ_acc;
  logic signed [ErrW-1:0] err_hist;
  logic [CountW-1:0]  block_count;
  logic               blocked;

  // These are raw 16-bit words for the next register load, indexed by register.
  // Bits above a register's width may carry junk that the block must drop.
  logic [DataW-1:0]   reg_word [0:7];

  ctl_word_t          drive_expect_q[$];
  ctl_word_t          want;
  int                 mismatches = 0;
  int                 cycle_cnt = 0;
  int                 tx_idle_pct = 0;
  int                 rx_stall_pct = 0;

  // Compute one control step. Sums are kept in 64 bits, with eight fraction
  // bits, so nothing can overflow before the clamps.
  function automatic ctl_word_t control_step(logic act, logic signed [15:0] meas,
                                             logic signed [15:0] tgt);
    logic signed [ErrW-1:0] err;
    longint e, sum, lim, clamped, mag, d;
    logic hit;
    ctl_word_t r;
    if (act == ActClear) begin
      integ_acc = 0;
      err_hist = '0;
      block_count = '0;
      blocked = 1'b0;
      r.drive = '0;
      r.stalled = 1'b0;
      return r;
    end
    err = tgt - meas;
    e = err;
    integ_acc += longint'(loop_cfg.gain_i) * e;
    // The raw sum sees the integral before the anti-windup clamp.
    sum = longint'(loop_cfg.gain_p) * e + integ_acc
        + longint'(loop_cfg.gain_d) * (e - longint'(err_hist));
    lim = longint'(loop_cfg.integral_bound) * 256;
    if (integ_acc > lim) integ_acc = lim;
    else if (integ_acc < -lim) integ_acc = -lim;

    // The stall logic only moves while the demand is at least 1% of full scale.
    if (sum * 100 >= longint'(loop_cfg.max_drive) * 256) begin
      if (tgt > 0) begin
        hit = (((e < 0) ? -e : e) * 10) > (longint'(tgt) * 9);
      end else if (tgt == 0) begin
        hit = (e != 0);
      end else begin
        hit = 1'b0;
      end
      if (hit) begin
        if (block_count != CountMax) block_count++;
      end else begin
        block_count = '0;
      end
      if (block_count > loop_cfg.stall_limit) blocked = 1'b1;
    end

    lim = longint'(loop_cfg.max_drive) * 256;
    clamped = (sum > lim) ? lim : ((sum < -lim) ? -lim : sum);
    err_hist = err;
    mag = (clamped < 0) ? -clamped : clamped;
    if (loop_cfg.deadband != 0 && mag < longint'(loop_cfg.deadband) * 256) begin
      d = 0;
    end else begin
      d = mag >> 8;
      if (clamped < 0) d = -d;
    end
    r.drive = d[DataW-1:0];
    r.stalled = blocked;
    return r;
  endfunction

  // Receiver side. The stall is redrawn on every cycle at the rate of the
  // current phase.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_stall_pct);
  end

  // Result monitor. The sampled outputs are the values from before this edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_expect_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, got drive %0d stalled %0b",
                 $time, drive_o, stalled_o);
      end else begin
        want = drive_expect_q.pop_front();
        if (drive_o !== want.drive) begin
          mismatches++;
          $display("%0t: drive expected %0d, got %0d", $time,
                   $signed(want.drive), drive_o);
        end
        if (stalled_o !== want.stalled) begin
          mismatches++;
          $display("%0t: stalled expected %0b, got %0b", $time,
                   want.stalled, stalled_o);
        end
      end
    end
  end

  // This watchdog ends a hung run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      1: begin tx_idle_pct = 52; rx_stall_pct = 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct = 52; end
      default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
    endcase
  endtask

  // Send one word and predict its result once the block has taken it. Valid
  // is only lowered for idle cycles. Back-to-back words keep it high.
  task automatic send_word(logic act, int meas, int tgt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    measured_i <= 16'(meas);
    target_i   <= 16'(tgt);
    do @(posedge clk_i); while (in_stall_o);
    drive_expect_q.push_back(control_step(act, 16'(meas), 16'(tgt)));
  endtask

  // Stop sending. Wait until every predicted result has arrived, then let
  // the pipeline settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (drive_expect_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Valid stays high from one write to the next. The caller lowers it.
  task automatic write_reg(logic [IdxW-1:0] idx, logic [DataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegGainP:      loop_cfg.gain_p = data;
      RegGainI:      loop_cfg.gain_i = data;
      RegGainD:      loop_cfg.gain_d = data;
      RegMaxDrive:   loop_cfg.max_drive = data[LimW-1:0];
      RegIntBound:   loop_cfg.integral_bound = data[LimW-1:0];
      RegDeadband:   loop_cfg.deadband = data[LimW-1:0];
      RegStallLimit: loop_cfg.stall_limit = data[CountW-1:0];
      default: ;
    endcase
  endtask

  // Write every register, and the unused index, once the block is idle.
  task automatic load_regs();
    wait_idle();
    write_reg(RegGainP, reg_word[RegGainP]);
    write_reg(RegGainI, reg_word[RegGainI]);
    write_reg(RegGainD, reg_word[RegGainD]);
    write_reg(RegMaxDrive, reg_word[RegMaxDrive]);
    write_reg(RegIntBound, reg_word[RegIntBound]);
    write_reg(RegDeadband, reg_word[RegDeadband]);
    write_reg(RegStallLimit, reg_word[RegStallLimit]);
    write_reg(RegUnused, reg_word[RegUnused]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(int kp, int ki, int kd, int max_d, int bound, int db,
                          int stall_lim);
    reg_word[RegGainP]      = 16'(kp);
    reg_word[RegGainI]      = 16'(ki);
    reg_word[RegGainD]      = 16'(kd);
    reg_word[RegMaxDrive]   = 16'(max_d);
    reg_word[RegIntBound]   = 16'(bound);
    reg_word[RegDeadband]   = 16'(db);
    reg_word[RegStallLimit] = 16'(stall_lim);
    reg_word[RegUnused]     = 16'($urandom);
    load_regs();
  endtask

  // Draw a register word. It is either zero, all ones, a small value or any
  // value. Junk goes in the bits above the register width.
  function automatic logic [DataW-1:0] rand_word(int w, int small_hi);
    logic [DataW-1:0] mask;
    logic [DataW-1:0] v;
    mask = 16'((32'd1 << w) - 1);
    case ($urandom_range(7))
      0: v = '0;
      1: v = mask;
      2, 3, 4: v = 16'($urandom_range(0, small_hi));
      default: v = 16'($urandom);
    endcase
    return (v & mask) | (16'($urandom) & ~mask);
  endfunction

  // With the reset register values all gains are zero, so drive stays at zero.
  task automatic test_reset_values();
    set_idling(0);
    send_word(ActRun, 100, 200);
    send_word(ActRun, -32768, 32767);
  endtask

  // This test uses the widest errors in both directions, all-ones words for
  // several registers and a clear with junk operands.
  task automatic test_field_extremes();
    set_regs(16'h0100, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 16'hFFFF);
    send_word(ActRun, -32768, 32767);
    send_word(ActRun, 32767, -32768);
    send_word(ActRun, 0, 0);
    send_word(ActRun, 32767, 32767);
    send_word(ActRun, -32768, -32768);
    send_word(ActClear, -1, -1);
  endtask

  // At a gain of one half, odd errors expose truncation toward zero. Small
  // errors fall inside the deadband, and a large one hits the output clamp.
  task automatic test_deadband_truncation();
    set_regs(16'h0080, 0, 0, 1000, 0, 3, 1000);
    send_word(ActRun, 0, 5);
    send_word(ActRun, 0, 6);
    send_word(ActRun, 6, 0);
    send_word(ActRun, 7, 0);
    send_word(ActRun, 0, 3);
    send_word(ActRun, -2500, 2500);
  endtask

  // The raw sum uses the integral before the clamp, so the sum can
  // exceed the bound by one step's worth.
  task automatic test_integral_clamp();
    set_regs(0, 16'h0100, 0, 32767, 4, 0, 1000);
    send_word(ActRun, 0, 3);
    send_word(ActRun, 0, 3);
    send_word(ActRun, 0, 3);
    send_word(ActRun, 10, 0);
  endtask

  // The count rises while the error stays above 90% of a positive target.
  // It holds while the demand is low. A negative target resets it, but the
  // flag stays set until a clear. A zero target with any error counts too.
  task automatic test_stall_flag();
    set_idling(3);
    set_regs(16'h0100, 0, 0, 100, 0, 0, 1);
    send_word(ActRun, 0, 10);
    send_word(ActRun, 0, 10);
    send_word(ActRun, 10, 10);
    send_word(ActRun, -100, -5);
    send_word(ActRun, -3, 0);
    send_word(ActClear, 1234, -4321);
  endtask

  // Hold a blocked motor long enough to saturate the count. At the top
  // limit the flag must never set. One step after the limit is lowered by one,
  // it must set.
  task automatic test_count_saturation();
    set_idling(0);
    set_regs(16'h0100, 0, 0, 100, 0, 0, 16'hFFFF);
    repeat (1030) send_word(ActRun, $urandom_range(0, 50), 1000);
    set_regs(16'h0100, 0, 0, 100, 0, 0, 1022);
    send_word(ActRun, 7, 1000);
    send_word(ActClear, 0, 0);
  endtask

  // Random segments. Most words belong to blocked-motor runs or to tracking
  // runs with random content. The rest are noise words, clears and pauses
  // that let the pipeline drain.
  task automatic test_random_segments(int segments, int per_seg);
    int sent, kind, len, tgt, meas, span;
    for (int s = 0; s < segments; s++) begin
      reg_word[RegGainP]      = rand_word(GainW, 1024);
      reg_word[RegGainI]      = rand_word(GainW, 64);
      reg_word[RegGainD]      = rand_word(GainW, 512);
      reg_word[RegMaxDrive]   = rand_word(LimW, 2000);
      reg_word[RegIntBound]   = rand_word(LimW, 500);
      reg_word[RegDeadband]   = rand_word(LimW, 20);
      reg_word[RegStallLimit] = rand_word(CountW, 30);
      reg_word[RegUnused]     = 16'($urandom);
      load_regs();
      set_idling(s);
      sent = 0;
      while (sent < per_seg) begin
        kind = $urandom_range(99);
        if (kind < 55) begin
          // The target is held while the measurement stays stuck near zero.
          len = $urandom_range(2, 30);
          tgt = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 32767);
          span = tgt / 16;
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) begin
              meas = int'($signed(16'($urandom)));
            end else if (tgt == 0) begin
              meas = int'($urandom_range(1, 2000));
              if ($urandom_range(1) == 1) meas = -meas;
            end else begin
              meas = int'($urandom_range(0, 2 * span)) - span;
            end
            send_word(ActRun, meas, tgt);
          end
          sent += len;
        end else if (kind < 70) begin
          // The measurement closes half the gap on each step.
          len = $urandom_range(2, 20);
          tgt = int'($signed(16'($urandom)));
          meas = int'($signed(16'($urandom)));
          for (int k = 0; k < len; k++) begin
            send_word(ActRun, meas, tgt);
            meas = meas + (tgt - meas) / 2;
          end
          sent += len;
        end else if (kind < 93) begin
          send_word(ActRun, int'($signed(16'($urandom))), int'($signed(16'($urandom))));
          sent++;
        end else if (kind < 97) begin
          send_word(ActClear, int'($signed(16'($urandom))), int'($signed(16'($urandom))));
          sent++;
        end else begin
          wait_idle();
        end
      end
    end
  endtask

  initial begin
    loop_cfg = '0;
    loop_cfg.max_drive = MaxDriveRst;
    loop_cfg.integral_bound = IntBoundRst;
    loop_cfg.deadband = DeadbandRst;
    loop_cfg.stall_limit = StallLimitRst;
    integ_acc = 0;
    err_hist = '0;
    block_count = '0;
    blocked = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_field_extremes();
    test_deadband_truncation();
    test_integral_clamp();
    test_stall_flag();
    test_count_saturation();
    test_random_segments(8, 55);

    wait_idle();
    if (mismatches == 0 && drive_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ pid_with_stall_detect.f @@
sv/pidsd_pkg.sv
sv/pidsd_step.sv
sv/pid_with_stall_detect.sv
test/tb_pid_with_stall_detect.sv
